// ----- hdl/rrts_pkg.sv -----
package rrts_pkg;

    localparam int TICK_W        = 32;
    localparam int NUM_TASKS_DEF = 8;
    localparam int MASK_W        = 8;
    localparam int TASK_OUT_W    = 3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_DELAY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TICK_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [TASK_OUT_W-1:0] current_task;
        logic [TICK_W-1:0]     tick_count;
        logic                  delay_taken;
        logic [MASK_W-1:0]     ready_mask;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INC,
        S_WAKE,
        S_DELAY,
        S_PICK,
        S_OUT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ----- hdl/rrts_ram.sv -----
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rrts_alu.sv -----
module rrts_alu
    import rrts_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [TICK_W-1:0] i_a,
    input  logic [TICK_W-1:0] i_b,
    output logic [TICK_W-1:0] o_sum,
    output logic              o_zero
);

    // one adder; subtract is a + ~b + 1
    logic [TICK_W-1:0] b_eff;
    logic              cin;

    assign b_eff  = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign cin    = (i_op == ALU_SUB);
    assign o_sum  = i_a + b_eff + TICK_W'(cin);
    assign o_zero = (o_sum == '0);

endmodule

// ----- hdl/round_robin_task_scheduler_unit.sv -----
// Round-robin task scheduler. Slot 0 is the idle task and is never blocked.
// A tick transaction (cmd = tick) advances a wrapping 32-bit tick count, wakes
// every blocked task whose wake tick equals the new count, then picks the next
// task. A delay transaction blocks the running task until count + delay_ticks
// and picks the next task; from the idle task it is refused (delay_taken = 0,
// nothing changes). The pick scans slots running+1 .. running (wrapping) and
// takes the first ready non-idle task, else slot 0. Every input transaction
// yields exactly one result transaction. Timing: one item at a time; the input
// is stalled from acceptance until its result is loaded in the output
// register. All 32-bit adds and wake compares go through one shared adder,
// and the wake ticks sit in a small RAM read one slot per cycle. A tick runs
// the wake sweep and then the pick scan; a delay runs only the pick scan, and
// a refused delay neither. A waiting result does not block acceptance of the
// next item.
module round_robin_task_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int MW = (NUM_TASKS > MASK_W) ? NUM_TASKS : MASK_W;
    localparam int PW = (TW > TASK_OUT_W) ? TW : TASK_OUT_W;
    localparam logic [MW-1:0] SLOT_MSK = {MW{1'b1}} >> (MW - NUM_TASKS);
    localparam logic [TW:0]   IDX_END  = (TW+1)'(NUM_TASKS);
    localparam logic [TW:0]   IDX_LAST = (TW+1)'(NUM_TASKS - 1);
    localparam logic [TW-1:0] SLOT_TOP = TW'(NUM_TASKS - 1);

    // control state
    t_state                r_state, n_state;
    logic [TICK_W-1:0]     r_ticks, n_ticks;
    logic [TW-1:0]         r_running, n_running;
    logic [NUM_TASKS-1:0]  r_blocked, n_blocked;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_out_valid, n_out_valid;

    // payload / scratch
    logic [TICK_W-1:0]     r_delay, n_delay;
    logic [TW:0]           r_idx, n_idx;
    logic [TW-1:0]         r_cand, n_cand;
    logic [TW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_taken, n_taken;
    t_out_item             r_out, n_out;

    // shared adder
    t_alu_op               alu_op;
    logic [TICK_W-1:0]     alu_a, alu_b, alu_sum;
    logic                  alu_zero;

    // wake-tick RAM
    logic                  ram_we;
    logic [TICK_W-1:0]     ram_rdata;

    logic                  in_acc;
    logic                  out_free;
    logic [TW-1:0]         pick_nxt;
    logic                  pick_hit;
    logic                  pick_last;
    logic                  wake_done;
    logic [MW-1:0]         blk_ext;
    logic [PW-1:0]         run_ext;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pick_nxt  = (r_cand == SLOT_TOP) ? '0 : r_cand + 1'b1;
    assign pick_hit  = (pick_nxt != '0) && !r_blocked[pick_nxt];
    assign pick_last = (r_idx == IDX_LAST);
    assign wake_done = (r_idx == IDX_END) && !r_rd_vld;
    assign blk_ext   = MW'(r_blocked);
    assign run_ext   = PW'(r_running);

    // ALU operand select
    always_comb begin
        alu_a  = r_ticks;
        alu_op = ALU_SUB;
        alu_b  = ram_rdata;
        case (r_state)
            S_INC: begin
                alu_op = ALU_ADD;
                alu_b  = TICK_W'(1);
            end
            S_DELAY: begin
                alu_op = ALU_ADD;
                alu_b  = r_delay;
            end
            default: begin
                alu_op = ALU_SUB;
                alu_b  = ram_rdata;
            end
        endcase
    end

    rrts_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_sum  (alu_sum),
        .o_zero (alu_zero)
    );

    assign ram_we = (r_state == S_DELAY) && (r_running != '0);

    rrts_ram #(
        .WIDTH (TICK_W),
        .DEPTH (NUM_TASKS)
    ) u_wake_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_running),
        .i_wdata (alu_sum),
        .i_raddr (r_idx[TW-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.cmd == CMD_TICK) ? S_INC : S_DELAY;
                end
            end
            S_INC: begin
                n_state = S_WAKE;
            end
            S_WAKE: begin
                if (wake_done) begin
                    n_state = S_PICK;
                end
            end
            S_DELAY: begin
                n_state = (r_running != '0) ? S_PICK : S_OUT;
            end
            S_PICK: begin
                if (pick_hit || pick_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath / outputs
    always_comb begin
        n_ticks     = r_ticks;
        n_running   = r_running;
        n_blocked   = r_blocked;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_delay     = r_delay;
        n_idx       = r_idx;
        n_cand      = r_cand;
        n_taken     = r_taken;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // result leaves the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_delay = i_in_data.delay_ticks;
                    n_taken = 1'b0;
                end
            end
            S_INC: begin
                n_ticks = alu_sum;
                n_idx   = (TW+1)'(1);
            end
            S_WAKE: begin
                // read issued here, its registered data compared the cycle after
                if (r_idx != IDX_END) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[TW-1:0];
                    n_idx    = r_idx + 1'b1;
                end
                if (r_rd_vld && r_blocked[r_rd_idx] && alu_zero) begin
                    n_blocked[r_rd_idx] = 1'b0;
                end
                if (wake_done) begin
                    n_idx  = '0;
                    n_cand = r_running;
                end
            end
            S_DELAY: begin
                if (r_running != '0) begin
                    n_blocked[r_running] = 1'b1;
                    n_taken = 1'b1;
                end
                n_idx  = '0;
                n_cand = r_running;
            end
            S_PICK: begin
                n_cand = pick_nxt;
                n_idx  = r_idx + 1'b1;
                if (pick_hit) begin
                    n_running = pick_nxt;
                end else if (pick_last) begin
                    n_running = '0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out.current_task = run_ext[TASK_OUT_W-1:0];
                    n_out.tick_count   = r_ticks;
                    n_out.delay_taken  = r_taken;
                    n_out.ready_mask   = MASK_W'(~blk_ext & SLOT_MSK);
                    n_out_valid        = 1'b1;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= '0;
            r_running   <= TW'(1);
            r_blocked   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ticks     <= n_ticks;
            r_running   <= n_running;
            r_blocked   <= n_blocked;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay  <= n_delay;
        r_idx    <= n_idx;
        r_cand   <= n_cand;
        r_rd_idx <= n_rd_idx;
        r_taken  <= n_taken;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
